// File: rtl/core/ics_pkg.sv
// ----------------------------------------------------------------------------
// ics_pkg
// Types and helpers shared by the internet checksum block with its
// optional TCP/UDP pseudo header.
// ----------------------------------------------------------------------------
`default_nettype none

package ics_pkg;

	// One packet byte with the fields that are sampled alongside the final byte.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic        use_pseudo;
		logic [31:0] src_addr;
		logic [31:0] dest_addr;
		logic [7:0]  protocol_num;
	} ics_in_t;

	// One checksum result, issued for the final byte of a packet.
	typedef struct packed {
		logic [15:0] checksum;
		logic [15:0] packet_length;
		logic        too_long;
	} ics_out_t;

	// Width of a ones-complement word.
	localparam int unsigned WORD_W = 16;

	// Width of an unfolded sum of up to eight 16-bit words.
	localparam int unsigned WIDE_W = WORD_W + 3;

	// Ones-complement addition of two words with the end-around carry.
	function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
	endfunction

endpackage : ics_pkg

`default_nettype wire

// File: rtl/core/ics_in_reg.sv
// ----------------------------------------------------------------------------
// ics_in_reg
// Input register of the checksum block. Holds one accepted byte until the
// accumulator can take it, and accepts a new byte in the same cycle as the
// held one moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module ics_in_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire ics_pkg::ics_in_t in_item,
	input  wire logic            advance,
	output logic                 valid_s1,
	output ics_pkg::ics_in_t     item_s1
);
	import ics_pkg::*;

	// The stage frees up when it is empty or when its byte moves on.
	assign in_ready = !valid_s1 || advance;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule : ics_in_reg

`default_nettype wire

// File: rtl/core/ics_accum.sv
// ----------------------------------------------------------------------------
// ics_accum
// Running ones-complement sum and byte count of the current packet. Works
// out the new state for the byte presented to it and, for the final byte,
// the finished checksum with the optional pseudo header folded in.
// ----------------------------------------------------------------------------
`default_nettype none

module ics_accum (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire ics_pkg::ics_in_t item,
	output ics_pkg::ics_out_t     result
);
	import ics_pkg::*;

	logic [WORD_W-1:0] running_sum_q;
	logic [WORD_W-1:0] byte_count_q;
	logic              length_overflow_q;

	logic [WORD_W-1:0] word_in;
	logic [WORD_W-1:0] sum_next;
	logic [WORD_W:0]   count_inc;
	logic [WORD_W-1:0] count_next;
	logic              overflow_next;
	logic [WIDE_W-1:0] pseudo_total;
	logic [WORD_W:0]   pseudo_fold1;
	logic [WORD_W-1:0] pseudo_sum;
	logic [WORD_W-1:0] final_sum;

	// A byte at an even position is the high half of its word.
	assign word_in = byte_count_q[0] ? {8'h00, item.data_byte} : {item.data_byte, 8'h00};

	assign sum_next = oc_add(running_sum_q, word_in);

	// Byte count wraps at 64 Ki and remembers that it did.
	assign count_inc     = {1'b0, byte_count_q} + {{WORD_W{1'b0}}, 1'b1};
	assign count_next    = count_inc[WORD_W-1:0];
	assign overflow_next = length_overflow_q | count_inc[WORD_W];

	// The pseudo header is added as one wide sum over the old running sum,
	// the new word and the six header words, then folded twice. A zero
	// total stays zero and any other total lands on the same value as a
	// chain of end-around additions would.
	assign pseudo_total = WIDE_W'(running_sum_q) + WIDE_W'(word_in)
		+ WIDE_W'(item.src_addr[31:16]) + WIDE_W'(item.src_addr[15:0])
		+ WIDE_W'(item.dest_addr[31:16]) + WIDE_W'(item.dest_addr[15:0])
		+ WIDE_W'(item.protocol_num) + WIDE_W'(count_next);
	assign pseudo_fold1 = {1'b0, pseudo_total[WORD_W-1:0]}
		+ {{(WORD_W - (WIDE_W - WORD_W) + 1){1'b0}}, pseudo_total[WIDE_W-1:WORD_W]};
	assign pseudo_sum = pseudo_fold1[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, pseudo_fold1[WORD_W]};

	assign final_sum = item.use_pseudo ? pseudo_sum : sum_next;

	// Result fields for a final byte.
	always_comb begin
		result.checksum      = ~final_sum;
		result.packet_length = count_next;
		result.too_long      = overflow_next;
	end

	// State returns to its reset values once a packet ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q     <= '0;
			byte_count_q      <= '0;
			length_overflow_q <= 1'b0;
		end else if (advance) begin
			if (item.last_byte) begin
				running_sum_q     <= '0;
				byte_count_q      <= '0;
				length_overflow_q <= 1'b0;
			end else begin
				running_sum_q     <= sum_next;
				byte_count_q      <= count_next;
				length_overflow_q <= overflow_next;
			end
		end
	end

`ifndef SYNTHESIS
	// A finished packet leaves the accumulator cleared.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.last_byte |=> running_sum_q == '0 && byte_count_q == '0
		&& !length_overflow_q)
		else $error("accumulator not cleared after final byte");

	// The overflow flag only rises when the count wraps to zero.
	a_overflow_on_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(length_overflow_q) |-> byte_count_q == '0)
		else $error("length overflow set without count wrap");

	// Without a byte moving in, the state holds.
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(running_sum_q) && $stable(byte_count_q)
		&& $stable(length_overflow_q))
		else $error("accumulator state changed without a byte");
`endif

endmodule : ics_accum

`default_nettype wire

// File: rtl/core/internet_checksum_pseudo_header.sv
// ----------------------------------------------------------------------------
// internet_checksum_pseudo_header
// Internet checksum over a packet streamed one byte per transfer, with an
// optional TCP/UDP pseudo header added on the final byte.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   in_item   input      in_valid / in_ready   ics_in_t: one packet byte
//   out_item  output     out_valid / out_ready ics_out_t: one checksum
//
// One byte is accepted every cycle while the output side keeps up.
// A result is registered in the output register when its final byte moves on;
// the path is the input register, the accumulator, the output register.
// A final byte waits in the input register only while an earlier result is
// still held in the output register, and the sender is held off for that time;
// a byte that is not final never waits.
// Reset clears the accumulator state and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module internet_checksum_pseudo_header (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire ics_pkg::ics_in_t  in_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output ics_pkg::ics_out_t      out_item
);
	import ics_pkg::*;

	logic     valid_s1;
	ics_in_t  item_s1;
	logic     advance;
	logic     load;
	ics_out_t result;
	logic     out_valid_q;
	ics_out_t out_item_q;

	// A byte moves on unless it is final and the output register is still full.
	assign advance = valid_s1 && (!item_s1.last_byte || !out_valid_q || out_ready);
	assign load    = advance && item_s1.last_byte;

	ics_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ics_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.result  (result)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	// A new result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(load && out_valid_q && !out_ready))
		else $error("result overwritten before transfer");

	// An accepted byte is held in the input register on the next cycle.
	a_in_captured: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted byte lost");

	// A loaded result is presented on the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("result not presented after load");
`endif

endmodule : internet_checksum_pseudo_header

`default_nettype wire
